// ===== src/pte_pkg.sv =====
// Shared constants and types for the partition table entry parser.
package pte_pkg;

    localparam int ENTRY_BYTES  = 32;
    localparam int ENTRY_COUNT  = 16;
    localparam int NAME_BYTES   = 16;
    localparam int SECTOR_BYTES = ENTRY_BYTES * ENTRY_COUNT;
    localparam int QUEUE_DEPTH  = 2;

    localparam int POS_W  = $clog2(SECTOR_BYTES);
    localparam int OFFS_W = $clog2(ENTRY_BYTES);
    localparam int IDX_W  = $clog2(ENTRY_COUNT);
    localparam int LEN_W  = $clog2(NAME_BYTES + 1);
    localparam int NAME_W = NAME_BYTES * 8;
    localparam int MAXE_W = 5;

    localparam logic [1:0] CFG_HEADS       = 2'd0;
    localparam logic [1:0] CFG_SECTORS     = 2'd1;
    localparam logic [1:0] CFG_MAX_ENTRIES = 2'd2;

    localparam logic [7:0]        HEADS_RESET       = 8'd8;
    localparam logic [7:0]        SECTORS_RESET     = 8'd17;
    localparam logic [MAXE_W-1:0] MAX_ENTRIES_RESET = 5'd16;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam int OFF_FLAGS0 = 0;
    localparam int OFF_FLAGS1 = 1;
    localparam int OFF_START  = 4;
    localparam int OFF_DATA   = 8;
    localparam int OFF_NAME   = 16;

    // entry_index, used, bootable, two LBAs, name, name_length
    localparam int TDATA_BITS = IDX_W + 2 + 64 + NAME_W + LEN_W;
    localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [7:0]        heads;
        logic [7:0]        sectors;
        logic [MAXE_W-1:0] entry_max;
    } pte_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              used;
        logic              bootable;
        logic              geo_err;
        logic              last;
        logic [31:0]       start_chs;
        logic [31:0]       data_chs;
        logic [NAME_W-1:0] name;
        logic [LEN_W-1:0]  name_len;
    } pte_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pte_queue_status_t;

endpackage

// ===== src/partition_table_entry_parser_top.sv =====
// Top level of the partition table entry parser: configuration registers and block wiring.
//
// channel   direction  handshake             payload
// s_        in         s_tvalid / s_tready   s_tdata: table_byte
// m_        out        m_tvalid / m_tready   m_tdata, m_tuser, m_tlast: one entry result
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data: register write
//
// One table byte is taken per cycle. After an entry's last byte is queued, its result
// passes a queue pop into the work register, the first multiply step (cyl*heads+head)
// into its register, then the second step (*sectors+sector) into the output register.
// Reset needs no clearing pass. The front stalls only on an entry's last byte while the
// entry queue is full; the back end holds its finished result until m_tready.
module partition_table_entry_parser_top #(
    parameter int QUEUE_DEPTH = pte_pkg::QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] table_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [3:0] entry_index, [4] entry_used, [5] bootable, [37:6] start address,
    // [69:38] data address, [133:70] name_low, [197:134] name_high, [202:198] name_length
    output logic [pte_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tuser,   // [0] geometry_error
    output logic                        m_tlast,   // last_entry
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [7:0]                  cfg_data
);

    pte_pkg::pte_cfg_t          cfg_reg;
    pte_pkg::pte_queue_status_t q_status;
    pte_pkg::pte_entry_t        push_data;
    pte_pkg::pte_entry_t        pop_data;
    logic                       push;
    logic                       pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.heads     <= pte_pkg::HEADS_RESET;
            cfg_reg.sectors   <= pte_pkg::SECTORS_RESET;
            cfg_reg.entry_max <= pte_pkg::MAX_ENTRIES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pte_pkg::CFG_HEADS:       cfg_reg.heads     <= cfg_data;
                pte_pkg::CFG_SECTORS:     cfg_reg.sectors   <= cfg_data;
                pte_pkg::CFG_MAX_ENTRIES: cfg_reg.entry_max <= cfg_data[pte_pkg::MAXE_W-1:0];
                default: ;
            endcase
        end
    end

    pte_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    pte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    pte_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .pop       (pop),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== src/pte_front.sv =====
// Front end: byte intake, entry gathering, name trimming and emit decision.
module pte_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  pte_pkg::pte_cfg_t             cfg,
    input  pte_pkg::pte_queue_status_t    q_status,
    output logic                          push,
    output pte_pkg::pte_entry_t           push_data
);

    logic [pte_pkg::POS_W-1:0]  pos_reg;
    logic [7:0]                 byte0_reg;
    logic [7:0]                 byte1_reg;
    logic [31:0]                start_chs_reg;
    logic [31:0]                data_chs_reg;
    logic [pte_pkg::NAME_W-1:0] name_reg;
    logic [pte_pkg::NAME_W-1:0] name_next;
    logic [pte_pkg::LEN_W-1:0]  name_len_reg;
    logic [pte_pkg::LEN_W-1:0]  name_len_next;
    logic                       name_end_reg;
    logic                       name_end_next;

    logic [pte_pkg::OFFS_W-1:0] offs;
    logic [pte_pkg::IDX_W-1:0]  idx;
    logic                       accept;
    logic                       at_last;
    logic                       name_phase;
    logic                       name_start;
    logic                       term;
    logic                       ended_eff;
    logic                       keep;
    logic                       geo_ok;
    logic                       sector_end;
    logic [pte_pkg::MAXE_W-1:0] limit;
    logic [pte_pkg::MAXE_W-1:0] idx_ext;
    logic                       in_range;
    logic                       is_last;

    assign offs       = pos_reg[pte_pkg::OFFS_W-1:0];
    assign idx        = pos_reg[pte_pkg::POS_W-1:pte_pkg::OFFS_W];
    assign at_last    = offs == pte_pkg::OFFS_W'(pte_pkg::ENTRY_BYTES - 1);
    assign s_tready   = !(at_last && q_status.full);
    assign accept     = s_tvalid && s_tready;
    assign name_phase = offs[pte_pkg::OFFS_W-1];
    assign name_start = offs == pte_pkg::OFFS_W'(pte_pkg::OFF_NAME);
    assign term       = (s_tdata == pte_pkg::CHAR_NUL) || (s_tdata == pte_pkg::CHAR_SPACE);
    assign ended_eff  = name_start ? 1'b0 : name_end_reg;
    assign keep       = !ended_eff && !term;

    always_comb begin
        name_next     = name_reg;
        name_len_next = name_len_reg;
        name_end_next = name_end_reg;
        if (name_phase) begin
            name_next[{offs[pte_pkg::OFFS_W-2:0], 3'b000} +: 8] = keep ? s_tdata : 8'h00;
            name_len_next = (name_start ? '0 : name_len_reg)
                          + {{(pte_pkg::LEN_W-1){1'b0}}, keep};
            name_end_next = ended_eff || term;
        end
    end

    assign geo_ok     = (cfg.heads != 8'd0) && (cfg.sectors != 8'd0);
    assign sector_end = pos_reg == pte_pkg::POS_W'(pte_pkg::SECTOR_BYTES - 1);
    assign limit      = (cfg.entry_max > pte_pkg::MAXE_W'(pte_pkg::ENTRY_COUNT))
                      ? pte_pkg::MAXE_W'(pte_pkg::ENTRY_COUNT) : cfg.entry_max;
    assign idx_ext    = {{(pte_pkg::MAXE_W-pte_pkg::IDX_W){1'b0}}, idx};
    assign in_range   = idx_ext < limit;
    assign is_last    = (idx_ext + pte_pkg::MAXE_W'(1)) == limit;

    assign push = accept && at_last && (geo_ok ? in_range : sector_end);

    always_comb begin
        push_data = '0;
        if (geo_ok) begin
            push_data.idx       = idx;
            push_data.used      = byte0_reg != 8'h00;
            push_data.bootable  = byte0_reg[7] && byte1_reg[7];
            push_data.last      = is_last;
            push_data.start_chs = start_chs_reg;
            push_data.data_chs  = data_chs_reg;
            push_data.name      = name_next;
            push_data.name_len  = name_len_next;
        end else begin
            push_data.geo_err = 1'b1;
            push_data.last    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_reg + pte_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (offs == pte_pkg::OFFS_W'(pte_pkg::OFF_FLAGS0)) begin
                byte0_reg <= s_tdata;
            end
            if (offs == pte_pkg::OFFS_W'(pte_pkg::OFF_FLAGS1)) begin
                byte1_reg <= s_tdata;
            end
            if (offs[pte_pkg::OFFS_W-1:2] == 3'(pte_pkg::OFF_START / 4)) begin
                start_chs_reg[{offs[1:0], 3'b000} +: 8] <= s_tdata;
            end
            if (offs[pte_pkg::OFFS_W-1:2] == 3'(pte_pkg::OFF_DATA / 4)) begin
                data_chs_reg[{offs[1:0], 3'b000} +: 8] <= s_tdata;
            end
            name_reg     <= name_next;
            name_len_reg <= name_len_next;
            name_end_reg <= name_end_next;
        end
    end

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("entry pushed into a full queue");

    a_push_at_entry_end: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> pos_reg[pte_pkg::OFFS_W-1:0] == '0)
        else $error("entry pushed away from an entry boundary");

endmodule

// ===== src/pte_queue.sv =====
// Short entry queue between the front end and the conversion back end.
module pte_queue #(
    parameter int DEPTH = pte_pkg::QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  pte_pkg::pte_entry_t        push_data,
    input  logic                       pop,
    output pte_pkg::pte_entry_t        pop_data,
    output pte_pkg::pte_queue_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pte_pkg::pte_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    assign status.full  = count_reg == CNT_W'(DEPTH);
    assign status.empty = count_reg == '0;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("pop from an empty queue");

endmodule

// ===== src/pte_back.sv =====
// Back end: CHS to LBA conversion over two multiply steps and the result register.
module pte_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pte_pkg::pte_cfg_t             cfg,
    input  pte_pkg::pte_queue_status_t    q_status,
    output logic                          pop,
    input  pte_pkg::pte_entry_t           pop_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pte_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    pte_pkg::pte_entry_t work_reg;
    logic [23:0]         p1_start_reg;
    logic [23:0]         p1_data_reg;
    logic [23:0]         p1_start;
    logic [23:0]         p1_data;
    logic [31:0]         lba_start;
    logic [31:0]         lba_data;
    logic                out_load;

    logic                       out_valid_reg;
    logic [pte_pkg::IDX_W-1:0]  out_idx_reg;
    logic                       out_used_reg;
    logic                       out_boot_reg;
    logic [31:0]                out_start_reg;
    logic [31:0]                out_data_reg;
    logic [pte_pkg::NAME_W-1:0] out_name_reg;
    logic [pte_pkg::LEN_W-1:0]  out_len_reg;
    logic                       out_geo_reg;
    logic                       out_last_reg;

    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;
    assign out_load = (state_reg == ST_MUL2) && (!out_valid_reg || m_tready);

    assign p1_start = 24'({8'h00, work_reg.start_chs[31:16]} * {16'h0000, cfg.heads})
                    + {16'h0000, work_reg.start_chs[15:8]};
    assign p1_data  = 24'({8'h00, work_reg.data_chs[31:16]} * {16'h0000, cfg.heads})
                    + {16'h0000, work_reg.data_chs[15:8]};

    assign lba_start = 32'({8'h00, p1_start_reg} * {24'h000000, cfg.sectors})
                     + {24'h000000, work_reg.start_chs[7:0]};
    assign lba_data  = 32'({8'h00, p1_data_reg} * {24'h000000, cfg.sectors})
                     + {24'h000000, work_reg.data_chs[7:0]};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (pop) begin
                state_next = ST_MUL1;
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: if (out_load) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            work_reg <= pop_data;
        end
        if (state_reg == ST_MUL1) begin
            p1_start_reg <= p1_start;
            p1_data_reg  <= p1_data;
        end
        if (out_load) begin
            out_idx_reg   <= work_reg.idx;
            out_used_reg  <= work_reg.used;
            out_boot_reg  <= work_reg.used && work_reg.bootable;
            out_start_reg <= work_reg.used ? lba_start : 32'h0;
            out_data_reg  <= work_reg.used ? lba_data : 32'h0;
            out_name_reg  <= work_reg.used ? work_reg.name : '0;
            out_len_reg   <= work_reg.used ? work_reg.name_len : '0;
            out_geo_reg   <= work_reg.geo_err;
            out_last_reg  <= work_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_geo_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(pte_pkg::TDATA_W-pte_pkg::TDATA_BITS){1'b0}},
                       out_len_reg, out_name_reg, out_data_reg, out_start_reg,
                       out_boot_reg, out_used_reg, out_idx_reg};

    a_geo_err_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_geo_reg) |-> (out_last_reg && !out_used_reg
            && out_idx_reg == '0 && out_start_reg == 32'h0))
        else $error("geometry error result carries entry data");

    a_mul_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL1) |=> (state_reg == ST_MUL2))
        else $error("conversion step skipped");

endmodule
